// File: hdl/lobm_pkg.sv
// Package with shared types and codes of the limit order book matcher.
package lobm_pkg;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_PARTIAL  = 3'd1;
  localparam logic [2:0] ST_FILLED   = 3'd2;
  localparam logic [2:0] ST_CANCEL   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_CREAD, S_CCHK, S_SREAD, S_SWRITE, S_MREAD,
    S_MCHK, S_IPREP, S_IREAD, S_ICHK, S_IWRITE, S_ACK
  } fsm_t;

  // One request from the controller to a side memory.
  typedef struct packed {
    logic        rd;
    logic [5:0]  raddr;
    logic        wr;
    logic [5:0]  waddr;
  } mem_ctl_t;

endpackage

// File: hdl/lobm_side_mem.sv
// One side of the book: a synchronous entry memory with registered read.
module lobm_side_mem #(
  parameter int DEPTH = 32,
  parameter int PW    = 32
) (
  input  logic                clk,
  input  lobm_pkg::mem_ctl_t  ctl,
  input  logic [PW+95:0]      wdata,
  output logic [PW+95:0]      rdata
);
  import lobm_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PW+95:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[ctl.waddr[AW-1:0]] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[ctl.raddr[AW-1:0]];
    end
  end
endmodule

// File: hdl/limit_order_book_matcher.sv
// Top level of the price-time priority limit order book matcher.
//
// Channel  Direction  Contents
// s_axis   in         tdata: order_id, limit_price, quantity, time_stamp;
//                     tuser: cmd, side, is_market
// m_axis   out        tdata: trade_number, buyer_id, seller_id, fill_price,
//                     fill_quantity, trade_time, left_quantity;
//                     tuser: kind, ack_status, rested; tlast: last
//
// Each side lives in one memory with registered reads; entry 0 is the best
// order. An item is taken in S_IDLE. A fill reads and then compares the
// head; emptying the head moves each entry behind it up one slot with a
// read and a write. A cancel reads and compares each entry, searching the
// bids and then the asks, then does the same move-up. Resting decides,
// moves each entry that ranks behind the new order down one slot and then
// places it; the ack follows. Items are taken one at a time, and any result
// waits while the output register holds an untaken transfer. Reset clears
// the counts and sets the trade counter to one.
module limit_order_book_matcher #(
  parameter int SIDE_CAPACITY = 32,
  parameter int PRICE_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: order_id[63:0], limit_price[95:64], quantity[127:96], time_stamp[191:128]
  input  logic [191:0]  s_axis_tdata,
  // tuser: cmd[0], side[1], is_market[2]
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: trade_number[63:0], buyer_id[127:64], seller_id[191:128],
  // fill_price[223:192], fill_quantity[255:224], trade_time[319:256],
  // left_quantity[351:320]
  output logic [351:0]  m_axis_tdata,
  // tuser: kind[0], ack_status[3:1], rested[4]
  output logic [4:0]    m_axis_tuser,
  output logic          m_axis_tlast
);
  import lobm_pkg::*;

  localparam int PW = PRICE_BITS;
  localparam int EW = PW + 96;
  localparam logic [5:0] CAP = 6'(SIDE_CAPACITY);

  // Entry layout: id[63:0], quantity[95:64], price[EW-1:96].
  fsm_t state, state_next;

  logic [5:0]    bid_count, ask_count;
  logic [63:0]   trade_counter;
  logic          cmd, buy, market;
  logic [63:0]   oid, ts;
  logic [PW-1:0] price;
  logic [31:0]   qty, left;
  logic [5:0]    idx;
  logic          side_ask;  // side memory the current phase works on
  logic [2:0]    status;
  logic          rested;

  mem_ctl_t bctl, actl;
  logic [EW-1:0] bwdata, awdata, brdata, ardata;

  lobm_side_mem #(.DEPTH(SIDE_CAPACITY), .PW(PW)) u_bid (
    .clk(clk), .ctl(bctl), .wdata(bwdata), .rdata(brdata));
  lobm_side_mem #(.DEPTH(SIDE_CAPACITY), .PW(PW)) u_ask (
    .clk(clk), .ctl(actl), .wdata(awdata), .rdata(ardata));

  // Read data and count of the side being worked on; own side for resting.
  logic [EW-1:0] cur_rd;
  logic [5:0]    cur_cnt, own_cnt;
  assign cur_rd  = side_ask ? ardata : brdata;
  assign cur_cnt = side_ask ? ask_count : bid_count;
  assign own_cnt = buy ? bid_count : ask_count;

  logic [PW-1:0] head_price;
  logic [31:0]   head_qty, fill;
  logic [63:0]   head_id;
  assign head_price = cur_rd[EW-1:96];
  assign head_qty   = cur_rd[95:64];
  assign head_id    = cur_rd[63:0];
  assign fill       = (left < head_qty) ? left : head_qty;

  // A limit buy crosses at or above the best ask, a limit sell at or below
  // the best bid; a market order always crosses.
  logic crosses;
  assign crosses = market || (buy ? (price >= head_price) : (price <= head_price));
  // The entry read ranks behind the new order and must move down one slot.
  logic loses;
  assign loses = buy ? (head_price < price) : (head_price > price);
  logic own_full;
  assign own_full = (own_cnt >= CAP);
  logic rest_it;
  assign rest_it = (left != 32'd0) && !market && !own_full;

  logic out_busy;
  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  logic          emit_trade, emit_ack;
  logic          rd, wr;
  logic [5:0]    raddr, waddr;
  logic [EW-1:0] wdata;

  // Output register: a new result may load when the previous transfer is
  // done or completes in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_trade) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {32'd0, ts, fill, 32'(head_price),
                        buy ? head_id : oid, buy ? oid : head_id,
                        trade_counter};
      m_axis_tuser  <= 5'd0;
      m_axis_tlast  <= 1'b0;
    end else if (emit_ack) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {left, 320'd0};
      m_axis_tuser  <= {rested, status, 1'b1};
      m_axis_tlast  <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = (s_axis_tuser[0] == CMD_CANCEL) ? S_CREAD : S_MREAD;
      end
      S_CREAD: begin
        if (idx >= cur_cnt) state_next = side_ask ? S_ACK : S_CREAD;
        else state_next = S_CCHK;
      end
      S_CCHK:   state_next = (head_id == oid) ? S_SREAD : S_CREAD;
      S_SREAD: begin
        if (idx >= cur_cnt) state_next = (cmd == CMD_CANCEL) ? S_ACK : S_MREAD;
        else state_next = S_SWRITE;
      end
      S_SWRITE: state_next = S_SREAD;
      S_MREAD: begin
        if (left == 32'd0 || cur_cnt == 6'd0) state_next = S_IPREP;
        else state_next = S_MCHK;
      end
      S_MCHK: begin
        if (!crosses) state_next = S_IPREP;
        else if (!out_busy) state_next = (head_qty == fill) ? S_SREAD : S_MREAD;
      end
      S_IPREP:  state_next = rest_it ? S_IREAD : S_ACK;
      S_IREAD:  state_next = (idx == 6'd0) ? S_IWRITE : S_ICHK;
      S_ICHK:   state_next = loses ? S_IREAD : S_IWRITE;
      S_IWRITE: state_next = S_ACK;
      S_ACK:    if (!out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory requests and result loads for the current state.
  always_comb begin
    rd = 1'b0;
    wr = 1'b0;
    raddr = idx;
    waddr = idx;
    wdata = cur_rd;
    emit_trade = 1'b0;
    emit_ack = 1'b0;
    unique case (state)
      S_CREAD:  rd = (idx < cur_cnt);
      S_SREAD:  rd = (idx < cur_cnt);
      S_SWRITE: begin
        // The entry read in the last cycle moves up one slot.
        wr = 1'b1;
        waddr = idx - 6'd1;
      end
      S_MREAD: begin
        raddr = 6'd0;
        rd = (left != 32'd0) && (cur_cnt != 6'd0);
      end
      S_MCHK: begin
        emit_trade = crosses && !out_busy;
        // A head that keeps some quantity is written back in place.
        waddr = 6'd0;
        wdata = {head_price, head_qty - fill, head_id};
        wr = crosses && !out_busy && (head_qty != fill);
      end
      S_IREAD: begin
        raddr = idx - 6'd1;
        rd = (idx != 6'd0);
      end
      S_ICHK:   wr = loses;
      S_IWRITE: begin
        wr = 1'b1;
        wdata = {price, left, oid};
      end
      S_ACK:    emit_ack = !out_busy;
      default: ;
    endcase
  end

  assign bctl = '{rd: rd && !side_ask, raddr: raddr, wr: wr && !side_ask, waddr: waddr};
  assign actl = '{rd: rd && side_ask, raddr: raddr, wr: wr && side_ask, waddr: waddr};
  assign bwdata = wdata;
  assign awdata = wdata;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bid_count <= 6'd0;
      ask_count <= 6'd0;
      trade_counter <= 64'd1;
      idx <= 6'd0;
      side_ask <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd    <= s_axis_tuser[0];
          buy    <= (s_axis_tuser[1] == SIDE_BUY);
          market <= s_axis_tuser[2];
          oid    <= s_axis_tdata[63:0];
          price  <= PW'(s_axis_tdata[95:64]);
          qty    <= s_axis_tdata[127:96];
          left   <= s_axis_tdata[127:96];
          ts     <= s_axis_tdata[191:128];
          idx    <= 6'd0;
          rested <= 1'b0;
          status <= ST_NEW;
          // A cancel searches the bids first; a buy matches against the asks.
          side_ask <= (s_axis_tuser[0] == CMD_CANCEL) ? 1'b0 :
                      (s_axis_tuser[1] == SIDE_BUY);
        end
        S_CREAD: if (idx >= cur_cnt) begin
          if (side_ask) begin
            status <= ST_NOTFOUND;
            left   <= 32'd0;
          end else begin
            side_ask <= 1'b1;
            idx <= 6'd0;
          end
        end
        S_CCHK: begin
          if (head_id == oid) begin
            status <= ST_CANCEL;
            left   <= head_qty;
          end
          idx <= idx + 6'd1;
        end
        S_SREAD: if (idx >= cur_cnt) begin
          if (side_ask) ask_count <= ask_count - 6'd1;
          else bid_count <= bid_count - 6'd1;
        end
        S_SWRITE: idx <= idx + 6'd1;
        S_MCHK: if (crosses && !out_busy) begin
          trade_counter <= trade_counter + 64'd1;
          left <= left - fill;
          if (head_qty == fill) idx <= 6'd1;
        end
        S_IPREP: begin
          if (left == 32'd0) status <= ST_FILLED;
          else if (!market && own_full) status <= ST_FULL;
          else if (left < qty) status <= ST_PARTIAL;
          else status <= ST_NEW;
          if (rest_it) begin
            side_ask <= !buy;
            idx <= own_cnt;
          end
        end
        S_ICHK: if (loses) idx <= idx - 6'd1;
        S_IWRITE: begin
          rested <= 1'b1;
          if (side_ask) ask_count <= ask_count + 6'd1;
          else bid_count <= bid_count + 6'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
